>>> hw/rtl/color_mask_fragment_generator_top_defines.svh
// ----------------------------------------------------------------------------
// Color mask fragment generator assertion macros
// Shared assertion macros; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef COLOR_MASK_FRAGMENT_GENERATOR_TOP_DEFINES_SVH
`define COLOR_MASK_FRAGMENT_GENERATOR_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CMFG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CMFG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMFG_ASSERT(lbl, prop, msg)
`define CMFG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/cmfg_pkg.sv
// ----------------------------------------------------------------------------
// Color mask fragment generator package
// Field widths, payload structs, status codes and controller types.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfg_pkg;

	localparam int ADDR_W    = 48;
	localparam int MASK_W    = 64;
	localparam int REP_W     = 32;
	localparam int CC_W      = 7;
	localparam int BYTES_W   = 19;
	localparam int STATUS_W  = 2;
	localparam int SEL_W     = 7;
	localparam int CNT_STEPS = 8;
	localparam int CNT_W     = $clog2(CNT_STEPS);
	localparam int BYTE_W    = MASK_W / CNT_STEPS;
	localparam int PC_W      = $clog2(BYTE_W + 1);

	localparam logic [CC_W-1:0]     CC_RESET      = 7'd16;
	localparam logic [BYTES_W-1:0]  BYTES_MAX     = '1;
	localparam logic [ADDR_W-1:0]   ADDR_MAX      = '1;

	localparam logic [STATUS_W-1:0] STAT_FRAG     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BEYOND   = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] phys_base;
		logic [ADDR_W-1:0] virt_base;
		logic [ADDR_W-1:0] region_bytes;
		logic [MASK_W-1:0] color_mask;
		logic [REP_W-1:0]  repetition;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   frag_phys;
		logic [ADDR_W-1:0]   frag_virt;
		logic [BYTES_W-1:0]  frag_bytes;
		logic                last;
		logic                final_repetition;
	} out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COUNT,
		S_MUL,
		S_CHECK,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic load;
		logic count_step;
		logic mul;
		logic setup;
		logic emit_special;
		logic scan_step;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic sel_zero;
		logic beyond;
		logic run_end;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/color_mask_fragment_generator_top.sv
// ----------------------------------------------------------------------------
// Color mask fragment generator
// Splits one colored region repetition into fragments, one per run of
// adjacent allowed colors, or returns a status result.
// ----------------------------------------------------------------------------
// Usage: an input transaction (in_valid, in_stall, in_data) carries one region
// and a repetition index. The block answers with one or more output
// transactions (out_valid, out_stall, out_data), the final one marked by last.
// The user must write the color count register through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block itself has no check
// for this. The register resets to 16 colors.
// Sequence: the mask is counted one byte per cycle, then the multiplies and
// the region check follow in their own states, and a status result is
// registered in the region check state once the output register is free.
// The run scan then steps one color per cycle while no fragment waits on a
// full output register, and each fragment leaves when its run ends.
// Reset clears the controller and the output valid and sets the color count
// back to 16.
// A stalled receiver holds the output register and pauses the scan at the
// next run end; input is stalled until the last result is registered, so
// the per-color scan sets the rate for fragmented items.
// ----------------------------------------------------------------------------
`default_nettype none

module color_mask_fragment_generator_top #(
	parameter int PAGE_SHIFT_BITS = 12,
	parameter int MAX_COLOR_COUNT = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [cmfg_pkg::CC_W-1:0] cfg_wr_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire cmfg_pkg::in_t             in_data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output cmfg_pkg::out_t                 out_data
);
	import cmfg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cmfg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	cmfg_dp #(
		.PAGE_SHIFT_BITS (PAGE_SHIFT_BITS),
		.MAX_COLOR_COUNT (MAX_COLOR_COUNT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

>>> hw/rtl/cmfg_dp.sv
// ----------------------------------------------------------------------------
// Color mask fragment generator datapath
// Color count register, mask alignment, color counting, address set-up,
// run scanning and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfg_dp #(
	parameter int PAGE_SHIFT_BITS = 12,
	parameter int MAX_COLOR_COUNT = 64
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [cmfg_pkg::CC_W-1:0] cfg_wr_data,
	input  wire cmfg_pkg::in_t             in_data,
	input  wire cmfg_pkg::cmd_t            cmd,
	output cmfg_pkg::sts_t                 sts,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output cmfg_pkg::out_t                 out_data
);
	import cmfg_pkg::*;

	localparam int IDX_W  = $clog2(MAX_COLOR_COUNT);
	localparam int LEN_W  = IDX_W + 1;
	localparam int PROD_W = REP_W + SEL_W;
	localparam int WIDE_W = PROD_W + PAGE_SHIFT_BITS + 2;
	localparam int FB_W   = LEN_W + PAGE_SHIFT_BITS;
	localparam logic [CC_W-1:0] CC_MAX = CC_W'(MAX_COLOR_COUNT);

	function automatic logic [ADDR_W-1:0] sat_addr(input logic [WIDE_W-1:0] v);
		logic [ADDR_W-1:0] r;
		if (v[WIDE_W-1:ADDR_W] != '0) begin
			r = ADDR_MAX;
		end else begin
			r = v[ADDR_W-1:0];
		end
		return r;
	endfunction

	logic [CC_W-1:0]   cc_q;
	logic [CC_W-1:0]   cc;
	logic [CC_W-1:0]   shamt;
	logic [MASK_W-1:0] aligned;

	logic [ADDR_W-1:0] phys_q;
	logic [ADDR_W-1:0] virt_q;
	logic [ADDR_W-1:0] size_q;
	logic [REP_W-1:0]  rep_q;
	logic [MASK_W-1:0] scan_q;
	logic [MASK_W-1:0] cnt_sh_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SEL_W-1:0]  sel_q;
	logic [PROD_W-1:0] prod_sel_q;
	logic [PROD_W-1:0] prod_cc_q;
	logic [WIDE_W-1:0] pbase_q;
	logic [WIDE_W-1:0] vcur_q;
	logic              fin_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  first_q;
	logic              in_run_q;
	logic              out_vld_q;
	out_t              out_q;

	logic [PC_W-1:0]   popcnt;
	logic [WIDE_W-1:0] rep_sel_sh;
	logic [WIDE_W-1:0] next_sh;
	logic [WIDE_W-1:0] vcur_init;
	logic [WIDE_W-1:0] pbase_init;
	logic              beyond;
	logic              fin;
	logic              bit_cur;
	logic              bit_nxt;
	logic              run_end;
	logic              scan_last;
	logic [IDX_W-1:0]  first_d;
	logic [LEN_W-1:0]  len;
	logic [FB_W-1:0]   bytes_full;
	logic [WIDE_W-1:0] bytes_wide;
	logic [WIDE_W-1:0] frag_phys_w;
	logic              out_free;
	logic              out_load;
	out_t              out_d;

	always_comb begin
		if (cc_q == '0) begin
			cc = CC_W'(1);
		end else if (cc_q > CC_MAX) begin
			cc = CC_MAX;
		end else begin
			cc = cc_q;
		end
	end

	// Color i ends up at the top bit after i left shifts; colors beyond the
	// count fall off the top and the vacated low bits are zero.
	assign shamt   = CC_W'(MASK_W) - cc;
	assign aligned = in_data.color_mask << shamt;

	always_comb begin
		popcnt = '0;
		for (int b = 0; b < BYTE_W; b++) begin
			popcnt = popcnt + PC_W'(cnt_sh_q[MASK_W-1-b]);
		end
	end

	assign rep_sel_sh = WIDE_W'(prod_sel_q) << PAGE_SHIFT_BITS;
	assign next_sh    = (WIDE_W'(prod_sel_q) + WIDE_W'(sel_q)) << PAGE_SHIFT_BITS;
	assign beyond     = rep_sel_sh >= WIDE_W'(size_q);
	assign fin        = next_sh >= WIDE_W'(size_q);
	assign vcur_init  = WIDE_W'(virt_q) + rep_sel_sh;
	assign pbase_init = WIDE_W'(phys_q) + (WIDE_W'(prod_cc_q) << PAGE_SHIFT_BITS);

	assign bit_cur     = scan_q[MASK_W-1];
	assign bit_nxt     = scan_q[MASK_W-2];
	assign run_end     = bit_cur & ~bit_nxt;
	assign scan_last   = (scan_q[MASK_W-3:0] == '0);
	assign first_d     = in_run_q ? first_q : idx_q;
	assign len         = LEN_W'(idx_q - first_d) + LEN_W'(1);
	assign bytes_full  = FB_W'(len) << PAGE_SHIFT_BITS;
	assign bytes_wide  = WIDE_W'(bytes_full);
	assign frag_phys_w = pbase_q + (WIDE_W'(first_d) << PAGE_SHIFT_BITS);

	assign out_free = ~out_vld_q | ~out_stall;

	always_comb begin
		out_load = 1'b0;
		out_d    = out_q;
		if (cmd.emit_special) begin
			out_load                = 1'b1;
			out_d.status            = (sel_q == '0) ? STAT_EMPTY : STAT_BEYOND;
			out_d.frag_phys         = '0;
			out_d.frag_virt         = '0;
			out_d.frag_bytes        = '0;
			out_d.last              = 1'b1;
			out_d.final_repetition  = (sel_q != '0);
		end else if (cmd.scan_step && run_end) begin
			out_load                = 1'b1;
			out_d.status            = STAT_FRAG;
			out_d.frag_phys         = sat_addr(frag_phys_w);
			out_d.frag_virt         = sat_addr(vcur_q);
			out_d.frag_bytes        = (bytes_wide > WIDE_W'(BYTES_MAX)) ?
				BYTES_MAX : bytes_wide[BYTES_W-1:0];
			out_d.last              = scan_last;
			out_d.final_repetition  = fin_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q      <= CC_RESET;
			cnt_q     <= '0;
			in_run_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cc_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				cnt_q    <= '0;
				in_run_q <= 1'b0;
			end else begin
				if (cmd.count_step) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (cmd.scan_step) begin
					in_run_q <= bit_cur & ~run_end;
				end
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			phys_q   <= in_data.phys_base;
			virt_q   <= in_data.virt_base;
			size_q   <= in_data.region_bytes;
			rep_q    <= in_data.repetition;
			scan_q   <= aligned;
			cnt_sh_q <= aligned;
			sel_q    <= '0;
			idx_q    <= '0;
		end
		if (cmd.count_step) begin
			sel_q    <= sel_q + SEL_W'(popcnt);
			cnt_sh_q <= cnt_sh_q << BYTE_W;
		end
		if (cmd.mul) begin
			prod_sel_q <= PROD_W'(rep_q) * PROD_W'(sel_q);
			prod_cc_q  <= PROD_W'(rep_q) * PROD_W'(cc);
		end
		if (cmd.setup) begin
			pbase_q <= pbase_init;
			vcur_q  <= vcur_init;
			fin_q   <= fin;
		end
		if (cmd.scan_step) begin
			scan_q  <= scan_q << 1;
			idx_q   <= idx_q + IDX_W'(1);
			first_q <= first_d;
			if (run_end) begin
				vcur_q <= vcur_q + bytes_wide;
			end
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		sts.cnt_last  = (cnt_q == CNT_W'(CNT_STEPS - 1));
		sts.sel_zero  = (sel_q == '0);
		sts.beyond    = beyond;
		sts.run_end   = run_end;
		sts.scan_last = scan_last;
		sts.out_free  = out_free;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/cmfg_ctrl.sv
// ----------------------------------------------------------------------------
// Color mask fragment generator controller
// Sequences loading, color counting, multiplication, region check and the
// run scan, and holds the input channel while an item is in work.
// ----------------------------------------------------------------------------
`default_nettype none
`include "color_mask_fragment_generator_top_defines.svh"

module cmfg_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire cmfg_pkg::sts_t sts,
	output cmfg_pkg::cmd_t      cmd
);
	import cmfg_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   special;

	assign special = sts.sel_zero | sts.beyond;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_COUNT;
				end
			end
			S_COUNT: begin
				if (sts.cnt_last) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!special) begin
					state_d = S_SCAN;
				end else if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.run_end && sts.out_free && sts.scan_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall         = 1'b1;
		cmd              = '0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_COUNT: begin
				cmd.count_step = 1'b1;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
			end
			S_CHECK: begin
				cmd.setup        = ~special;
				cmd.emit_special = special & sts.out_free;
			end
			S_SCAN: begin
				cmd.scan_step = ~sts.run_end | sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	`CMFG_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.load, cmd.count_step, cmd.mul, cmd.setup, cmd.emit_special, cmd.scan_step}), "more than one datapath command at once")
	`CMFG_ASSERT(a_frag_needs_room, (cmd.scan_step && sts.run_end) |-> sts.out_free, "fragment issued while output register is occupied")
	`CMFG_ASSERT(a_special_needs_room, cmd.emit_special |-> sts.out_free, "status result issued while output register is occupied")
	`CMFG_ASSERT(a_load_to_count, cmd.load |=> (state_q == S_COUNT), "accepted transaction did not start color counting")
	`CMFG_ASSERT(a_setup_to_scan, cmd.setup |=> (state_q == S_SCAN), "region set-up did not lead to the run scan")

endmodule

`default_nettype wire
